>>> src/ogcr_pkg.sv
package ogcr_pkg;

  localparam int SAMPLE_WORDS  = 4;
  localparam int WORD_BITS     = 32;
  localparam int WINDOW_BITS   = SAMPLE_WORDS * WORD_BITS;
  localparam int GCR_BITS      = 21;
  localparam int MAX_KEPT_RUNS = 21;
  localparam int LIMIT_W       = 8;
  localparam int RUN_W         = 5;
  localparam int NBITS_W       = 5;
  localparam int USED_W        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int OUT_DATA_W    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_THREE = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_ONE_RST   = 8'd9;
  localparam logic [LIMIT_W-1:0] LIMIT_TWO_RST   = 8'd14;
  localparam logic [LIMIT_W-1:0] LIMIT_THREE_RST = 8'd20;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RUN_COUNT = 2'd1,
    ST_RUN_LONG  = 2'd2,
    ST_TOO_MANY  = 2'd3
  } dstat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
    logic emit;
  } ogcr_cmd_t;

  typedef struct packed {
    logic walk_more;
    logic out_free;
  } ogcr_sts_t;

  function automatic logic [RUN_W-1:0] lead_zeros(input logic [WORD_BITS-1:0] v);
    logic [RUN_W-1:0] n;
    logic             found;
    n     = '0;
    found = 1'b0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = RUN_W'(WORD_BITS - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> src/ogcr_ctrl.sv
module ogcr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ogcr_pkg::ogcr_sts_t sts,
  output ogcr_pkg::ogcr_cmd_t cmd
);
  import ogcr_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (!sts.walk_more) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_WALK: begin
        cmd.step = sts.walk_more;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

>>> src/ogcr_dp.sv
module ogcr_dp #(
  parameter int MAX_RUNS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [ogcr_pkg::WINDOW_BITS-1:0]      in_tdata,
  input  logic                                  cfg_valid,
  input  logic [ogcr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ogcr_pkg::LIMIT_W-1:0]          cfg_data,
  input  ogcr_pkg::ogcr_cmd_t                   cmd,
  output ogcr_pkg::ogcr_sts_t                   sts,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ogcr_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import ogcr_pkg::*;

  localparam int CW = $clog2(MAX_RUNS + 1);

  logic [LIMIT_W-1:0]     lim1_r, lim2_r, lim3_r;
  logic [WINDOW_BITS-1:0] win_r;
  logic                   high_r;
  logic [USED_W-1:0]      used_r;
  logic [CW-1:0]          count_r;
  logic [RUN_W-1:0]       pend_r;
  logic                   pend_vld_r;
  logic [GCR_BITS-1:0]    gcr_r;
  logic [NBITS_W-1:0]     nbits_r;
  logic                   conv_done_r;
  logic                   long_r;
  logic                   out_valid_r;
  logic [GCR_BITS-1:0]    out_word_r;
  dstat_t                 out_stat_r;

  logic [WORD_BITS-1:0]   probe;
  logic [RUN_W-1:0]       run;
  logic [WINDOW_BITS-1:0] win_nxt;
  logic                   conv_en;
  logic [1:0]             len;
  logic                   too_long;
  logic [GCR_BITS-1:0]    gcr_nxt;
  logic [NBITS_W-1:0]     nbits_nxt;
  logic [CW-1:0]          kept;
  logic [NBITS_W-1:0]     pad;
  logic [GCR_BITS-1:0]    word_pad;
  dstat_t                 stat_nxt;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim1_r <= LIMIT_ONE_RST;
      lim2_r <= LIMIT_TWO_RST;
      lim3_r <= LIMIT_THREE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LIMIT_ONE:   lim1_r <= cfg_data;
        CFG_LIMIT_TWO:   lim2_r <= cfg_data;
        CFG_LIMIT_THREE: lim3_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // run walk
  assign probe = high_r ? ~win_r[WINDOW_BITS-1 -: WORD_BITS] : win_r[WINDOW_BITS-1 -: WORD_BITS];
  assign run   = lead_zeros(probe);

  assign sts.walk_more = (used_r < USED_W'(WINDOW_BITS)) && (count_r < CW'(MAX_RUNS)) &&
                         (probe != '0);
  assign sts.out_free  = !out_valid_r || out_tready;

  always_comb begin
    if (win_r[2*WORD_BITS-1 -: WORD_BITS] != '0) begin
      win_nxt = win_r << run;
    end else begin
      win_nxt = {win_r[WINDOW_BITS-1 -: 2*WORD_BITS] << run, win_r[2*WORD_BITS-1:0]};
    end
  end

  // run to gcr bits, one run behind the walk
  assign conv_en = pend_vld_r && !conv_done_r && (cmd.step || (cmd.flush && high_r));

  always_comb begin
    too_long = 1'b0;
    len      = 2'd1;
    if ({3'b000, pend_r} < lim1_r) begin
      len = 2'd1;
    end else if ({3'b000, pend_r} < lim2_r) begin
      len = 2'd2;
    end else if ({3'b000, pend_r} < lim3_r) begin
      len = 2'd3;
    end else begin
      too_long = 1'b1;
    end
    gcr_nxt   = (gcr_r << len) | (GCR_BITS'(1) << (len - 2'd1));
    nbits_nxt = nbits_r + NBITS_W'(len);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r  <= 1'b0;
      conv_done_r <= 1'b0;
      long_r      <= 1'b0;
      count_r     <= '0;
      used_r      <= '0;
    end else if (cmd.load) begin
      pend_vld_r  <= 1'b0;
      conv_done_r <= 1'b0;
      long_r      <= 1'b0;
      count_r     <= '0;
      used_r      <= '0;
    end else begin
      if (cmd.step) begin
        pend_vld_r <= 1'b1;
        count_r    <= count_r + CW'(1);
        used_r     <= used_r + USED_W'(run);
      end
      if (conv_en) begin
        if (too_long) begin
          long_r      <= 1'b1;
          conv_done_r <= 1'b1;
        end else if (nbits_nxt >= NBITS_W'(GCR_BITS)) begin
          conv_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win_r   <= {in_tdata[WORD_BITS-1:0], in_tdata[2*WORD_BITS-1 -: WORD_BITS],
                  in_tdata[3*WORD_BITS-1 -: WORD_BITS], in_tdata[4*WORD_BITS-1 -: WORD_BITS]};
      high_r  <= in_tdata[WORD_BITS-1];
      gcr_r   <= '0;
      nbits_r <= '0;
    end else begin
      if (cmd.step) begin
        win_r  <= win_nxt;
        high_r <= !high_r;
        pend_r <= run;
      end
      if (conv_en && !too_long) begin
        gcr_r   <= gcr_nxt;
        nbits_r <= nbits_nxt;
      end
    end
  end

  // status and padding
  always_comb begin
    kept = (high_r || count_r == '0) ? count_r : count_r - CW'(1);
    pad  = NBITS_W'(GCR_BITS) - nbits_r;
    word_pad = (gcr_r << pad) | ((GCR_BITS'(1) << pad) >> 1);
    if (kept < CW'(2) || kept > CW'(MAX_KEPT_RUNS)) begin
      stat_nxt = ST_RUN_COUNT;
    end else if (long_r) begin
      stat_nxt = ST_RUN_LONG;
    end else if (nbits_r > NBITS_W'(GCR_BITS)) begin
      stat_nxt = ST_TOO_MANY;
    end else begin
      stat_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_stat_r <= stat_nxt;
      out_word_r <= (stat_nxt == ST_OK) ? word_pad : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_stat_r, out_word_r};

endmodule

>>> src/oversampled_telemetry_gcr_recovery.sv
// Recovers a 21-bit GCR word from an oversampled telemetry window.
// Input stream: one request is a 128-sample window in in_tdata, four 32-bit
// words with the earliest sample in the top bit of each word.
// Output stream: one request per window, the GCR word and a decode status.
// Config channel: cfg_index selects a run-length threshold, cfg_data its
// value; cfg_ready is always high, write only while no window is in flight.
// One run is split off per cycle by a leading-zero count on the head word, which
// sets the rate; the conversion of each run to GCR bits trails the walk by one
// run in the same cycles. The block takes no new window while one is walked.
// A new window is taken only after the previous result is loaded into the
// output register, so one result may wait there while the next window runs.
// If the receiver stalls, the block holds its result and stops before
// loading the next one; no request is dropped.
// Reset: thresholds return to 9, 14 and 20 samples, both streams go idle.
module oversampled_telemetry_gcr_recovery #(
  parameter int MAX_RUNS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // samples_first, samples_second, samples_third, samples_fourth
  input  logic [ogcr_pkg::WINDOW_BITS-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // gcr_word, decode_status, zero pad
  output logic [ogcr_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ogcr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ogcr_pkg::LIMIT_W-1:0]        cfg_data
);
  import ogcr_pkg::*;

  ogcr_cmd_t cmd;
  ogcr_sts_t sts;

  assign cfg_ready = 1'b1;

  ogcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ogcr_dp #(
    .MAX_RUNS (MAX_RUNS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> src/ogcr_chk.sv
module ogcr_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ogcr_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import ogcr_pkg::*;

  // one window at a time
  a_one_window: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a window is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_word_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[GCR_BITS+1:GCR_BITS] != ST_OK |-> out_tdata[GCR_BITS-1:0] == '0)
    else $error("gcr word not zero on failed decode");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1] == 1'b0)
    else $error("pad bit set in result");

endmodule

bind oversampled_telemetry_gcr_recovery ogcr_chk u_ogcr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ogcr_pkg::*;

  localparam int WALK_RUN_LIMIT = 24;
  localparam int SETTLE_CYCLES  = 32;
  localparam int CYCLE_LIMIT    = 600000;

  typedef struct packed {
    logic [GCR_BITS-1:0] gcr;
    dstat_t              status;
  } gcr_result_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [WINDOW_BITS-1:0]  in_tdata   = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index  = CFG_LIMIT_ONE;
  logic [LIMIT_W-1:0]      cfg_data   = '0;

  logic [LIMIT_W-1:0] lim_one   = LIMIT_ONE_RST;
  logic [LIMIT_W-1:0] lim_two   = LIMIT_TWO_RST;
  logic [LIMIT_W-1:0] lim_three = LIMIT_THREE_RST;

  gcr_result_t gcr_expect_q[$];
  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  int          mismatches    = 0;
  int          windows_sent  = 0;
  int          limit_sets    = 0;
  int          status_seen[4] = '{0, 0, 0, 0};
  int          cycle_count   = 0;

  oversampled_telemetry_gcr_recovery dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // walk the window as runs, then convert the kept runs to gcr bits
  function automatic gcr_result_t decode_window(input logic [WINDOW_BITS-1:0] win);
    logic [31:0] w0, w1, w2, w3, probe, gcr;
    int          runs [WALK_RUN_LIMIT];
    int          count, left, run, nbits, len, pad;
    logic        lvl;
    gcr_result_t r;
    w0 = win[31:0];
    w1 = win[63:32];
    w2 = win[95:64];
    w3 = win[127:96];
    lvl = w0[31];
    left = WINDOW_BITS;
    count = 0;
    gcr = '0;
    nbits = 0;
    r.status = ST_OK;
    while (left > 0 && count < WALK_RUN_LIMIT) begin
      probe = lvl ? ~w0 : w0;
      if (probe == 0) break;
      run = 0;
      while (run < 32 && !probe[31 - run]) run++;
      runs[count] = run;
      count++;
      w0 = (w0 << run) | (w1 >> (32 - run));
      w1 = (w1 << run) | (w2 >> (32 - run));
      if (w2 != 0) begin
        w2 = (w2 << run) | (w3 >> (32 - run));
        w3 = w3 << run;
      end
      lvl = ~lvl;
      left -= run;
    end
    // a walk ending low loses its last run to the idle line
    if (!lvl && count > 0) count--;
    if (count < 2 || count > MAX_KEPT_RUNS) begin
      r.status = ST_RUN_COUNT;
    end else begin
      for (int i = 0; i < count; i++) begin
        if (runs[i] < int'(lim_one)) len = 1;
        else if (runs[i] < int'(lim_two)) len = 2;
        else if (runs[i] < int'(lim_three)) len = 3;
        else begin
          r.status = ST_RUN_LONG;
          break;
        end
        gcr = ((gcr << len) | (32'd1 << (len - 1))) & 32'h00FF_FFFF;
        nbits += len;
        if (nbits >= GCR_BITS) break;
      end
      if (r.status == ST_OK && nbits > GCR_BITS) r.status = ST_TOO_MANY;
    end
    if (r.status == ST_OK) begin
      pad = GCR_BITS - nbits;
      gcr = gcr << pad;
      if (pad > 0) gcr = gcr | (32'd1 << (pad - 1));
      r.gcr = gcr[GCR_BITS-1:0];
    end else begin
      r.gcr = '0;
    end
    return r;
  endfunction

  function automatic logic [WINDOW_BITS-1:0] pack_words(input logic [31:0] first, second,
                                                       third, fourth);
    return {fourth, third, second, first};
  endfunction

  // sample 0 sits at seq[127]; samples past the runs take the tail level
  function automatic logic [WINDOW_BITS-1:0] frame_from_runs(input logic first_lvl,
                                                            input int lens[$],
                                                            input logic tail_lvl);
    logic [WINDOW_BITS-1:0] seq;
    logic                   lvl;
    int                     pos;
    seq = {WINDOW_BITS{tail_lvl}};
    lvl = first_lvl;
    pos = 0;
    foreach (lens[k]) begin
      for (int b = 0; b < lens[k]; b++) begin
        if (pos < WINDOW_BITS) seq[WINDOW_BITS - 1 - pos] = lvl;
        pos++;
      end
      lvl = ~lvl;
    end
    return pack_words(seq[127:96], seq[95:64], seq[63:32], seq[31:0]);
  endfunction

  function automatic int pick_run_len(input int long_pct);
    int lo, hi;
    if ($urandom_range(99) < long_pct) begin
      lo = int'(lim_three);
      hi = 31;
    end else begin
      case ($urandom_range(2))
        0: begin
          lo = 1;
          hi = int'(lim_one) - 1;
        end
        1: begin
          lo = int'(lim_one);
          hi = int'(lim_two) - 1;
        end
        default: begin
          lo = int'(lim_two);
          hi = int'(lim_three) - 1;
        end
      endcase
    end
    if (lo < 1) lo = 1;
    if (hi > 31) hi = 31;
    if (lo > hi) return $urandom_range(31, 1);
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [WINDOW_BITS-1:0] random_frame(input int long_pct);
    int   lens[$];
    int   nruns;
    logic first_lvl, tail_lvl;
    nruns = $urandom_range(23, 2);
    for (int k = 0; k < nruns; k++) lens.push_back(pick_run_len(long_pct));
    first_lvl = 1'($urandom_range(1));
    tail_lvl = 1'($urandom_range(1));
    return frame_from_runs(first_lvl, lens, tail_lvl);
  endfunction

  function automatic logic [WINDOW_BITS-1:0] noisy_window();
    logic [WINDOW_BITS-1:0] w;
    int                     idx;
    idx = $urandom_range(WINDOW_BITS - 1);
    case ($urandom_range(3))
      0: w = {$urandom, $urandom, $urandom, $urandom};
      1: begin
        w = random_frame(10);
        w[idx] = ~w[idx];
      end
      2: begin
        w = random_frame(10);
        w[95:64] = '0;
      end
      default: begin
        w = {$urandom, $urandom, $urandom, $urandom};
        w[95:64] = '0;
      end
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 20) $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] data);
    gcr_result_t want;
    if (gcr_expect_q.size() == 0) begin
      report_mismatch("result with no request pending", 32'(data), 32'd0);
      return;
    end
    want = gcr_expect_q.pop_front();
    status_seen[int'(want.status)]++;
    if (data[GCR_BITS-1:0] !== want.gcr)
      report_mismatch("gcr_word", 32'(data[GCR_BITS-1:0]), 32'(want.gcr));
    if (data[GCR_BITS+1:GCR_BITS] !== want.status)
      report_mismatch("decode_status", 32'(data[GCR_BITS+1:GCR_BITS]), 32'(want.status));
    if (data[OUT_DATA_W-1:GCR_BITS+2] !== '0)
      report_mismatch("pad bits", 32'(data[OUT_DATA_W-1:GCR_BITS+2]), 32'd0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
    out_tready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               gcr_expect_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_window(input logic [WINDOW_BITS-1:0] win);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= win;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gcr_expect_q.push_back(decode_window(win));
    windows_sent++;
  endtask

  task automatic wait_idle(input int settle);
    in_tvalid <= 1'b0;
    while (gcr_expect_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= LIMIT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LIMIT_ONE:   lim_one   = LIMIT_W'(value);
      CFG_LIMIT_TWO:   lim_two   = LIMIT_W'(value);
      CFG_LIMIT_THREE: lim_three = LIMIT_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_limits(input int one, input int two, input int three);
    wait_idle(SETTLE_CYCLES);
    write_limit(CFG_LIMIT_ONE, one);
    write_limit(CFG_LIMIT_TWO, two);
    write_limit(CFG_LIMIT_THREE, three);
    cfg_valid <= 1'b0;
    limit_sets++;
  endtask

  task automatic run_random_frames(input int n, input int noise_pct, input int long_pct,
                                   input int pause_every);
    for (int k = 0; k < n; k++) begin
      if (pause_every > 0 && k > 0 && k % pause_every == 0) wait_idle(0);
      if ($urandom_range(99) < noise_pct) send_window(noisy_window());
      else send_window(random_frame(long_pct));
    end
  endtask

  task automatic test_directed_windows();
    int lens[$];
    in_idle_pct = 0;
    out_stall_pct = 0;
    send_window('0);
    send_window('1);
    send_window({4{32'hAAAA_AAAA}});
    send_window({4{32'h5555_5555}});
    send_window(pack_words(32'hFFFF_0000, 32'h0, 32'h0, 32'h0));
    lens = '{5, 5, 11, 17, 5};
    send_window(frame_from_runs(1'b0, lens, 1'b1));
    // exactly two kept runs, then a single one
    lens = '{5, 5};
    send_window(frame_from_runs(1'b1, lens, 1'b1));
    lens = '{5};
    send_window(frame_from_runs(1'b0, lens, 1'b1));
    lens = '{5, 25, 5};
    send_window(frame_from_runs(1'b0, lens, 1'b1));
    // a full word at one level ends the walk early
    lens = '{5, 40, 5};
    send_window(frame_from_runs(1'b0, lens, 1'b1));
    lens = '{17, 17, 17, 17, 17, 17, 17};
    send_window(frame_from_runs(1'b0, lens, 1'b1));
    lens = '{17, 17, 17, 17, 17, 17, 11, 11};
    send_window(frame_from_runs(1'b1, lens, 1'b1));
    lens.delete();
    repeat (21) lens.push_back(5);
    send_window(frame_from_runs(1'b0, lens, 1'b1));
    lens.push_back(5);
    send_window(frame_from_runs(1'b1, lens, 1'b1));
    repeat (2) lens.push_back(5);
    send_window(frame_from_runs(1'b0, lens, 1'b1));
    // runs on each side of every threshold
    lens = '{8, 9, 13, 14, 19};
    send_window(frame_from_runs(1'b0, lens, 1'b1));
    lens = '{8, 20, 5};
    send_window(frame_from_runs(1'b1, lens, 1'b1));
    lens = '{31, 31, 31};
    send_window(frame_from_runs(1'b0, lens, 1'b1));
    // zero third word stops the later words from moving
    send_window(pack_words(32'h00FF_00FF, 32'h0F0F_0F0F, 32'h0, 32'hFFFF_0000));
    send_window(pack_words(32'hFFF0_0000, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF));
    send_window(pack_words(32'hDEAD_BEEF, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98));
  endtask

  task automatic test_default_frames();
    in_idle_pct = 0;
    out_stall_pct = 0;
    run_random_frames(250, 10, 8, 0);
  endtask

  task automatic test_sender_gaps();
    set_limits(4, 8, 12);
    in_idle_pct = 66;
    out_stall_pct = 0;
    run_random_frames(200, 10, 8, 0);
  endtask

  task automatic test_receiver_stalls();
    set_limits(128, 128, 128);
    in_idle_pct = 0;
    out_stall_pct = 66;
    run_random_frames(100, 10, 8, 0);
    set_limits(6, 11, 17);
    run_random_frames(100, 10, 8, 0);
  endtask

  task automatic test_both_idle();
    set_limits(20, 14, 9);
    in_idle_pct = 26;
    out_stall_pct = 26;
    run_random_frames(200, 10, 8, 0);
  endtask

  task automatic test_threshold_extremes();
    in_idle_pct = 0;
    out_stall_pct = 0;
    set_limits(1, 1, 1);
    run_random_frames(60, 10, 8, 0);
    set_limits(1, 2, 3);
    run_random_frames(70, 10, 8, 0);
    set_limits(1, 128, 128);
    run_random_frames(70, 10, 8, 0);
  endtask

  task automatic test_drain_pauses();
    set_limits(9, 14, 20);
    in_idle_pct = 26;
    out_stall_pct = 26;
    run_random_frames(150, 10, 8, 25);
  endtask

  task automatic test_noise_windows();
    in_idle_pct = 26;
    out_stall_pct = 26;
    repeat (3) begin
      set_limits($urandom_range(128, 1), $urandom_range(128, 1), $urandom_range(128, 1));
      run_random_frames(50, 100, 8, 0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_windows();
    test_default_frames();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_threshold_extremes();
    test_drain_pauses();
    test_noise_windows();
    wait_idle(SETTLE_CYCLES + 8);
    $display("%0d windows decoded over %0d threshold settings, idle and stall up to 66%%",
             windows_sent, limit_sets);
    $display("status seen: ok %0d, run count %0d, run too long %0d, too many bits %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
